// ===== hw/rtl/nsd_pkg.sv =====
// Package for the NMEA sentence deframer: status codes, ASCII constants,
// the verdict record type and the hex digit decoder.
// No dependencies.
package nsd_pkg;

    // Verdict codes reported on the status field.
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_MISMATCH = 3'd1,
        ST_BAD_HEX  = 3'd2,
        ST_NO_START = 3'd3,
        ST_TOO_LONG = 3'd4
    } status_t;

    // Framing characters.
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_STAR   = 8'h2A;

    // Number of address characters captured after the marker.
    localparam int ADDR_CHARS = 5;

    // Widths fixed by the result fields.
    localparam int FLEN_W = 13;

    // One verdict as it travels from the framer to the output buffer.
    typedef struct packed {
        status_t     status;
        logic        start_is_bang;
        logic [39:0] address_chars;
        logic [12:0] frame_length;
        logic [7:0]  received_checksum;
        logic [7:0]  computed_checksum;
    } verdict_t;

    // Decoded hex digit: bad is set for anything but 0-9, A-F, a-f.
    typedef struct packed {
        logic       bad;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] b);
        hex_digit_t d;
        logic [7:0] t;
        d = '{bad: 1'b1, value: 4'd0};
        t = 8'd0;
        if (b inside {[8'h30:8'h39]}) begin
            t = b - 8'h30;
            d = '{bad: 1'b0, value: t[3:0]};
        end else if (b inside {[8'h41:8'h46]}) begin
            t = b - 8'h37;
            d = '{bad: 1'b0, value: t[3:0]};
        end else if (b inside {[8'h61:8'h66]}) begin
            t = b - 8'h57;
            d = '{bad: 1'b0, value: t[3:0]};
        end
        return d;
    endfunction

    function automatic logic is_marker(input logic [7:0] b);
        return (b == CH_DOLLAR) || (b == CH_BANG);
    endfunction

endpackage

// ===== hw/rtl/nsd_framer.sv =====
// Sentence framer: holds the per-sentence state and builds one verdict
// when the second checksum digit arrives. Depends on nsd_pkg.
module nsd_framer
    import nsd_pkg::*;
#(
    parameter int MAX_LEN = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    input  logic        chk_en,
    output logic        verdict_valid,
    output verdict_t    verdict
);

    // The length counter saturates one above MAX_LEN.
    localparam int LEN_W = $clog2(MAX_LEN + 2);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);

    typedef enum logic [1:0] {
        PH_BODY,
        PH_DIG1,
        PH_DIG2
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic             have_start_reg, have_start_next;
    logic [7:0]       xor_reg, xor_next;
    logic [39:0]      addr_reg, addr_next;
    logic [2:0]       addr_cnt_reg, addr_cnt_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [3:0]       first_digit_reg, first_digit_next;
    logic             digit_err_reg, digit_err_next;
    logic             bang_reg, bang_next;

    hex_digit_t       hd;
    logic             byte_is_marker;
    logic [LEN_W-1:0] len_inc;
    logic             hs;
    logic             derr;
    logic [LEN_W-1:0] len_end;
    logic [LEN_W-1:0] len_sat;
    logic [31:0]      len_wide;
    logic [7:0]       rx_sum;
    logic [39:0]      addr_ins;
    status_t          st;

    assign hd             = hex_decode(data_byte);
    assign byte_is_marker = is_marker(data_byte);
    assign len_inc        = (len_reg <= LEN_MAX) ? len_reg + LEN_W'(1) : len_reg;

    // A marker among the digits drops the start; only a started sentence counts the digits into the length.
    assign hs      = have_start_reg && !byte_is_marker;
    assign derr    = digit_err_reg || hd.bad;
    assign len_end = hs ? len_inc : len_reg;
    assign rx_sum  = derr ? 8'd0 : {first_digit_reg, hd.value};

    // Place the next address character below those already captured.
    always_comb
    begin
        case (addr_cnt_reg)
            3'd0:    addr_ins = {data_byte, 32'd0};
            3'd1:    addr_ins = {8'd0, data_byte, 24'd0};
            3'd2:    addr_ins = {16'd0, data_byte, 16'd0};
            3'd3:    addr_ins = {24'd0, data_byte, 8'd0};
            3'd4:    addr_ins = {32'd0, data_byte};
            default: addr_ins = 40'd0;
        endcase
    end

    // Verdict in priority order.
    always_comb
    begin
        if (!hs)
            st = ST_NO_START;
        else if (len_end > LEN_MAX)
            st = ST_TOO_LONG;
        else if (!chk_en)
            st = ST_OK;
        else if (derr)
            st = ST_BAD_HEX;
        else if (rx_sum != xor_reg)
            st = ST_MISMATCH;
        else
            st = ST_OK;
    end

    assign len_sat  = (len_end > LEN_MAX) ? LEN_MAX : len_end;
    assign len_wide = 32'(len_sat);

    always_comb
    begin
        verdict.status            = st;
        verdict.start_is_bang     = hs ? bang_reg : 1'b0;
        verdict.address_chars     = hs ? addr_reg : 40'd0;
        verdict.frame_length      = hs ? len_wide[FLEN_W-1:0] : 13'd0;
        verdict.received_checksum = rx_sum;
        verdict.computed_checksum = hs ? xor_reg : 8'd0;
    end

    assign verdict_valid = accept && (phase_reg == PH_DIG2);

    // Next state for one accepted byte.
    always_comb
    begin
        phase_next       = phase_reg;
        have_start_next  = have_start_reg;
        xor_next         = xor_reg;
        addr_next        = addr_reg;
        addr_cnt_next    = addr_cnt_reg;
        len_next         = len_reg;
        first_digit_next = first_digit_reg;
        digit_err_next   = digit_err_reg;
        bang_next        = bang_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_BODY:
                begin
                    if (byte_is_marker)
                    begin
                        have_start_next = 1'b1;
                        bang_next       = (data_byte == CH_BANG);
                        xor_next        = 8'd0;
                        addr_next       = 40'd0;
                        addr_cnt_next   = 3'd0;
                        len_next        = LEN_W'(1);
                    end
                    else if (data_byte == CH_STAR)
                    begin
                        phase_next       = PH_DIG1;
                        digit_err_next   = 1'b0;
                        first_digit_next = 4'd0;
                        if (have_start_reg)
                            len_next = len_inc;
                    end
                    else if (have_start_reg)
                    begin
                        xor_next = xor_reg ^ data_byte;
                        if (addr_cnt_reg < 3'(ADDR_CHARS))
                        begin
                            addr_next     = addr_reg | addr_ins;
                            addr_cnt_next = addr_cnt_reg + 3'd1;
                        end
                        len_next = len_inc;
                    end
                end
                PH_DIG1:
                begin
                    phase_next       = PH_DIG2;
                    have_start_next  = hs;
                    digit_err_next   = derr;
                    first_digit_next = hd.value;
                    len_next         = len_end;
                end
                default:
                begin
                    // Second digit: verdict goes out, frame state clears.
                    phase_next       = PH_BODY;
                    have_start_next  = 1'b0;
                    xor_next         = 8'd0;
                    addr_next        = 40'd0;
                    addr_cnt_next    = 3'd0;
                    len_next         = '0;
                    first_digit_next = 4'd0;
                    digit_err_next   = 1'b0;
                    bang_next        = 1'b0;
                end
            endcase
        end
    end

    // Frame state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_BODY;
            have_start_reg  <= 1'b0;
            xor_reg         <= 8'd0;
            addr_reg        <= 40'd0;
            addr_cnt_reg    <= 3'd0;
            len_reg         <= '0;
            first_digit_reg <= 4'd0;
            digit_err_reg   <= 1'b0;
            bang_reg        <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            have_start_reg  <= have_start_next;
            xor_reg         <= xor_next;
            addr_reg        <= addr_next;
            addr_cnt_reg    <= addr_cnt_next;
            len_reg         <= len_next;
            first_digit_reg <= first_digit_next;
            digit_err_reg   <= digit_err_next;
            bang_reg        <= bang_next;
        end
    end

endmodule

// ===== hw/rtl/nsd_obuf.sv =====
// Two-entry verdict buffer: a registered output slot plus a skid slot,
// so the input side keeps moving while a verdict waits. Depends on nsd_pkg.
module nsd_obuf
    import nsd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  verdict_t push_data,
    output logic     full,
    output logic     out_valid,
    input  logic     out_ready,
    output verdict_t head
);

    logic [1:0] count_reg, count_next;
    verdict_t   slot0_reg, slot0_next;
    verdict_t   slot1_reg, slot1_next;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign head      = slot0_reg;

    // Slot update; a push never arrives while both slots are full.
    always_comb
    begin
        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        case (count_reg)
            2'd0:
            begin
                if (push)
                begin
                    slot0_next = push_data;
                    count_next = 2'd1;
                end
            end
            2'd1:
            begin
                if (push && pop)
                    slot0_next = push_data;
                else if (push)
                begin
                    slot1_next = push_data;
                    count_next = 2'd2;
                end
                else if (pop)
                    count_next = 2'd0;
            end
            2'd2:
            begin
                if (pop)
                begin
                    slot0_next = slot1_reg;
                    count_next = 2'd1;
                end
            end
            default:
                count_next = 2'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    // Payload slots carry no reset.
    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

// ===== hw/rtl/nmea_sentence_deframer_core.sv =====
// NMEA sentence deframer top level: byte input channel, verdict output
// channel and the checksum check enable register.
// Depends on nsd_pkg, nsd_framer and nsd_obuf.
//
// Usage: received bytes enter one per item on in_valid/in_ready/data_byte.
// The last '$' or '!' before a '*' opens a sentence; the two bytes after
// the '*' close it, and exactly one verdict item then leaves on
// out_valid/out_ready with status and the framing fields. Other bytes
// produce no item.
// Throughput is one byte per cycle while in_ready is high; each byte updates
// the frame state in the cycle it is accepted. The verdict is registered
// into the output buffer when the second checksum digit is accepted.
// A two-entry output buffer holds verdicts: while one waits, bytes keep
// flowing, and in_ready drops only when both entries are occupied.
// Reset clears the frame state, empties the buffer and sets checking on.
// cfg_wr_en/cfg_wr_data write checksum_check_enable whenever enabled.
module nmea_sentence_deframer_core
    import nsd_pkg::*;
#(
    parameter int MAX_LEN = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic        start_is_bang,
    output logic [39:0] address_chars,
    output logic [12:0] frame_length,
    output logic [7:0]  received_checksum,
    output logic [7:0]  computed_checksum
);

    logic     chk_en_reg;
    logic     accept;
    logic     buf_full;
    logic     verdict_valid;
    verdict_t verdict;
    verdict_t head;

    // Checksum check enable register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chk_en_reg <= 1'b1;
        else if (cfg_wr_en)
            chk_en_reg <= cfg_wr_data;
    end

    assign in_ready = !buf_full;
    assign accept   = in_valid && in_ready;

    nsd_framer #(
        .MAX_LEN (MAX_LEN)
    ) u_framer (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (data_byte),
        .chk_en        (chk_en_reg),
        .verdict_valid (verdict_valid),
        .verdict       (verdict)
    );

    nsd_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (verdict_valid),
        .push_data (verdict),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    // Output fields come straight from the head slot.
    assign status            = head.status;
    assign start_is_bang     = head.start_is_bang;
    assign address_chars     = head.address_chars;
    assign frame_length      = head.frame_length;
    assign received_checksum = head.received_checksum;
    assign computed_checksum = head.computed_checksum;

endmodule

// ===== hw/rtl/nsd_checker.sv =====
// Port-level checker for the NMEA sentence deframer, bound to the top
// level. Depends on nsd_pkg and nmea_sentence_deframer_core.
module nsd_checker
    import nsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  status,
    input  logic        start_is_bang,
    input  logic [39:0] address_chars,
    input  logic [12:0] frame_length,
    input  logic [7:0]  received_checksum,
    input  logic [7:0]  computed_checksum
);

    // A stalled item stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped while stalled");

    // A stalled item keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(status) && $stable(frame_length)
            && $stable(received_checksum) && $stable(computed_checksum))
        else $error("verdict changed while stalled");

    // Without a start marker the framing fields are zero.
    a_no_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_NO_START |-> !start_is_bang
            && address_chars == 40'd0 && frame_length == 13'd0
            && computed_checksum == 8'd0)
        else $error("no-start verdict carries framing data");

    // A mismatch means the two sums really differ.
    a_mismatch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_MISMATCH |-> received_checksum != computed_checksum)
        else $error("mismatch reported on equal checksums");

    // A bad hex digit reads as a zero received checksum.
    a_bad_hex: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_BAD_HEX |-> received_checksum == 8'd0)
        else $error("bad hex verdict with nonzero received checksum");

endmodule

bind nmea_sentence_deframer_core nsd_checker u_nsd_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .start_is_bang     (start_is_bang),
    .address_chars     (address_chars),
    .frame_length      (frame_length),
    .received_checksum (received_checksum),
    .computed_checksum (computed_checksum)
);

// ===== verif/testbench.sv =====
// Self-checking testbench for nmea_sentence_deframer_core: a directed byte table,
// then random sentence streams checked against a behavioral deframer model.
// Depends on nsd_pkg and the nmea_sentence_deframer_core RTL.
module testbench
    import nsd_pkg::*;
;

    localparam int MAX_LEN     = 4096;
    localparam int STALL_LIMIT = 3000;

    // Frame phase of the behavioral deframer.
    typedef enum logic [1:0] {
        FR_BODY,
        FR_HI,
        FR_LO
    } frame_phase_t;

    // How the two checksum digits of a generated sentence are formed.
    typedef enum int {
        DIG_RIGHT,
        DIG_RANDOM,
        DIG_BAD,
        DIG_MARKER
    } digit_mode_t;

    // One row of the directed table; typed rows carry their verdict.
    typedef struct {
        logic [7:0] b;
        bit         typed;
        verdict_t   v;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic        start_is_bang;
    logic [39:0] address_chars;
    logic [12:0] frame_length;
    logic [7:0]  received_checksum;
    logic [7:0]  computed_checksum;

    // Model state, mirrors the block after reset.
    frame_phase_t fr_phase = FR_BODY;
    bit           fr_open = 1'b0;
    logic [7:0]   fr_xor = 8'h00;
    logic [39:0]  fr_addr = 40'h0;
    int           fr_addr_n = 0;
    int           fr_len = 0;
    logic [3:0]   fr_hi = 4'h0;
    bit           fr_bad = 1'b0;
    bit           fr_bang = 1'b0;
    bit           chk_en = 1'b1;

    verdict_t   pending_verdicts[$];
    stim_row_t  dir_rows[$];
    logic [7:0] frame_bytes[$];
    int         fail_count = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    bit         hold_req = 1'b0;

    nmea_sentence_deframer_core #(
        .MAX_LEN(MAX_LEN)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .data_byte(data_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .start_is_bang(start_is_bang),
        .address_chars(address_chars),
        .frame_length(frame_length),
        .received_checksum(received_checksum),
        .computed_checksum(computed_checksum)
    );

    always #6 clk = ~clk;

    // Returns {bad, value} for one checksum digit character.
    function automatic logic [4:0] nibble_of(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39)
            return {1'b0, 4'(b - 8'h30)};
        if (b >= 8'h41 && b <= 8'h46)
            return {1'b0, 4'(b - 8'h41 + 8'd10)};
        if (b >= 8'h61 && b <= 8'h66)
            return {1'b0, 4'(b - 8'h61 + 8'd10)};
        return 5'h10;
    endfunction

    // The length counter stops one above the maximum.
    function automatic void grow_len();
        if (fr_len <= MAX_LEN)
            fr_len++;
    endfunction

    // Advances the model by one byte; returns 1 when the byte ends a frame.
    function automatic bit deframe_byte(input logic [7:0] b, output verdict_t v);
        logic [4:0] d;
        logic [7:0] rx;
        bit         marker;
        v = '0;
        marker = (b == CH_DOLLAR) || (b == CH_BANG);
        if (fr_phase == FR_BODY) begin
            if (marker) begin
                fr_open = 1'b1;
                fr_bang = (b == CH_BANG);
                fr_xor = 8'h00;
                fr_addr = 40'h0;
                fr_addr_n = 0;
                fr_len = 1;
            end else if (b == CH_STAR) begin
                fr_phase = FR_HI;
                fr_bad = 1'b0;
                fr_hi = 4'h0;
                if (fr_open)
                    grow_len();
            end else if (fr_open) begin
                fr_xor ^= b;
                if (fr_addr_n < ADDR_CHARS) begin
                    fr_addr[8 * (ADDR_CHARS - 1 - fr_addr_n) +: 8] = b;
                    fr_addr_n++;
                end
                grow_len();
            end
            return 1'b0;
        end

        // Checksum digits: a marker here cancels the sentence.
        d = nibble_of(b);
        if (marker)
            fr_open = 1'b0;
        if (d[4])
            fr_bad = 1'b1;
        if (fr_open)
            grow_len();
        if (fr_phase == FR_HI) begin
            fr_hi = d[3:0];
            fr_phase = FR_LO;
            return 1'b0;
        end

        rx = fr_bad ? 8'h00 : {fr_hi, d[3:0]};
        if (!fr_open)
            v.status = ST_NO_START;
        else if (fr_len > MAX_LEN)
            v.status = ST_TOO_LONG;
        else if (!chk_en)
            v.status = ST_OK;
        else if (fr_bad)
            v.status = ST_BAD_HEX;
        else if (rx != fr_xor)
            v.status = ST_MISMATCH;
        else
            v.status = ST_OK;
        if (fr_open) begin
            v.start_is_bang = fr_bang;
            v.address_chars = fr_addr;
            v.frame_length = FLEN_W'((fr_len > MAX_LEN) ? MAX_LEN : fr_len);
            v.computed_checksum = fr_xor;
        end
        v.received_checksum = rx;

        fr_phase = FR_BODY;
        fr_open = 1'b0;
        fr_xor = 8'h00;
        fr_addr = 40'h0;
        fr_addr_n = 0;
        fr_len = 0;
        fr_hi = 4'h0;
        fr_bad = 1'b0;
        fr_bang = 1'b0;
        return 1'b1;
    endfunction

    function automatic verdict_t mk_verdict(input status_t s, input logic bang,
                                            input logic [39:0] addr, input logic [12:0] len,
                                            input logic [7:0] rx, input logic [7:0] cx);
        return {s, bang, addr, len, rx, cx};
    endfunction

    function automatic void add_row(input logic [7:0] b, input bit typed, input verdict_t v);
        stim_row_t r;
        r.b = b;
        r.typed = typed;
        r.v = v;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_row(s[i], 1'b0, '0);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10)
            return 8'h30 + {4'h0, n};
        return (lower ? 8'h61 : 8'h41) + {4'h0, n} - 8'd10;
    endfunction

    // Any byte that is neither a marker nor the star.
    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == CH_DOLLAR || b == CH_BANG || b == CH_STAR);
        return b;
    endfunction

    // Appends one sentence with a random marker and body to frame_bytes.
    function automatic void build_frame(input int body_len, input digit_mode_t mode);
        logic [7:0] sum;
        logic [7:0] b;
        logic [7:0] hi;
        logic [7:0] lo;
        sum = 8'h00;
        frame_bytes.push_back($urandom_range(1) ? CH_BANG : CH_DOLLAR);
        repeat (body_len) begin
            b = body_byte();
            sum ^= b;
            frame_bytes.push_back(b);
        end
        frame_bytes.push_back(CH_STAR);
        hi = hex_char(sum[7:4], 1'($urandom_range(1)));
        lo = hex_char(sum[3:0], 1'($urandom_range(1)));
        case (mode)
            DIG_RANDOM:
            begin
                hi = hex_char(4'($urandom_range(15)), 1'($urandom_range(1)));
                lo = hex_char(4'($urandom_range(15)), 1'($urandom_range(1)));
            end
            DIG_BAD:
            begin
                if ($urandom_range(1))
                    hi = 8'($urandom_range(255));
                else
                    lo = 8'($urandom_range(255));
            end
            DIG_MARKER:
            begin
                if ($urandom_range(1))
                    hi = $urandom_range(1) ? CH_BANG : CH_DOLLAR;
                else
                    lo = $urandom_range(1) ? CH_BANG : CH_DOLLAR;
            end
            default:
            begin
            end
        endcase
        frame_bytes.push_back(hi);
        frame_bytes.push_back(lo);
    endfunction

    // Offers one byte, waits for it to be taken and records its verdict if any.
    task automatic push_byte(input logic [7:0] b, input bit typed, input verdict_t tv);
        verdict_t pv;
        bit       ends;
        // Each cycle before the offer idles with the sender's idle chance.
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        ends = deframe_byte(b, pv);
        if (typed)
            pending_verdicts.push_back(tv);
        else if (ends)
            pending_verdicts.push_back(pv);
    endtask

    // Writes the enable once the output side has gone quiet.
    task automatic write_check_enable(input bit en);
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= en;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        chk_en = en;
    endtask

    // Mostly well-formed sentences, with junk, restarts, lone stars and noise mixed in.
    task automatic run_random(input int n_items);
        int          sent;
        int          pick;
        int          len;
        int          r;
        digit_mode_t mode;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 0);
            r = $urandom_range(9);
            mode = (r < 5) ? DIG_RIGHT : ((r < 8) ? DIG_RANDOM : DIG_BAD);
            if (pick < 10) begin
                repeat ($urandom_range(1, 4)) frame_bytes.push_back(body_byte());
                build_frame(len, mode);
            end else if (pick < 20) begin
                frame_bytes.push_back($urandom_range(1) ? CH_BANG : CH_DOLLAR);
                repeat ($urandom_range(0, 6)) frame_bytes.push_back(body_byte());
                build_frame(len, mode);
            end else if (pick < 28) begin
                frame_bytes.push_back(CH_STAR);
                frame_bytes.push_back(hex_char(4'($urandom_range(15)),
                                               1'($urandom_range(1))));
                frame_bytes.push_back(8'($urandom_range(255)));
            end else if (pick < 33) begin
                build_frame(len, DIG_MARKER);
            end else if (pick < 40) begin
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(5))
                        0: frame_bytes.push_back(CH_DOLLAR);
                        1: frame_bytes.push_back(CH_BANG);
                        2: frame_bytes.push_back(CH_STAR);
                        default: frame_bytes.push_back(8'($urandom_range(255)));
                    endcase
                end
            end else begin
                build_frame(len, mode);
            end
            foreach (frame_bytes[i])
                push_byte(frame_bytes[i], 1'b0, '0);
            sent += frame_bytes.size();
            frame_bytes.delete();
        end
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Output side: checks each verdict and throttles out_ready.
    initial begin
        verdict_t want;
        int       hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) begin
                if (pending_verdicts.size() == 0) begin
                    $error("verdict item arrived with none expected");
                    fail_count++;
                end else begin
                    want = pending_verdicts.pop_front();
                    check_field("status", want.status, status);
                    check_field("start_is_bang", want.start_is_bang, start_is_bang);
                    check_field("address_chars", want.address_chars, address_chars);
                    check_field("frame_length", want.frame_length, frame_length);
                    check_field("received_checksum", want.received_checksum,
                                received_checksum);
                    check_field("computed_checksum", want.computed_checksum,
                                computed_checksum);
                end
            end
            // A long hold-off lets the output buffer fill and back-pressure the input.
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Ends the run if neither channel moves an item for too long.
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        wait (rst_n === 1'b1);
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // Stimulus sequence.
    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sentences with checking at its reset value.
        // Star with no marker and non-hex digits.
        add_text("*z");
        add_row("Z", 1'b1, mk_verdict(ST_NO_START, 1'b0, 40'h0, 13'd0, 8'h00, 8'h00));
        // Junk before a marker, then a repeated marker and uppercase digits.
        add_row(8'hFF, 1'b0, '0);
        add_text("$!J*4");
        add_row("A", 1'b1, mk_verdict(ST_OK, 1'b1, 40'h4A_0000_0000, 13'd5, 8'h4A, 8'h4A));
        // More than five address characters and a wrong lowercase checksum.
        add_text("$GPGGA,*7");
        add_row("b", 1'b1,
                mk_verdict(ST_MISMATCH, 1'b0, 40'h47_5047_4741, 13'd10, 8'h7B, 8'h7A));
        // A marker in place of a checksum digit cancels the sentence.
        add_text("$*!");
        add_row("0", 1'b1, mk_verdict(ST_NO_START, 1'b0, 40'h0, 13'd0, 8'h00, 8'h00));
        // A zero byte as a checksum digit.
        add_text("$*");
        add_row(8'h00, 1'b0, '0);
        add_row("0", 1'b1, mk_verdict(ST_BAD_HEX, 1'b0, 40'h0, 13'd4, 8'h00, 8'h00));
        foreach (dir_rows[i])
            push_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].v);

        // Random phases under changing idle patterns and settings.
        write_check_enable(1'b0);
        send_idle_pct = 38;
        recv_idle_pct = 62;
        run_random(430);

        write_check_enable(1'b1);
        send_idle_pct = 62;
        recv_idle_pct = 38;
        run_random(430);

        write_check_enable(1'b0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        run_random(430);

        write_check_enable(1'b1);
        run_random(430);

        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (pending_verdicts.size() != 0) begin
            $error("%0d verdict items never arrived", pending_verdicts.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
